### src/lfu_pkg.sv
// Shared types and constants for the LFU frame replacement block.
// No dependencies; used by the interfaces, the cell and the top level.
package lfu_pkg;

  localparam int FRAMES   = 32;
  localparam int KEY_BITS = 8;
  localparam int CNT_W    = 32;
  localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OCC_W    = 6;
  localparam int CFG_W    = 6;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [OCC_W-1:0]    occ_t;
  typedef logic [CFG_W-1:0]    cfg_t;

  // search word that walks down the row of cells
  typedef struct packed {
    logic vld;
    key_t key;
    logic found;
    idx_t hit_idx;
    logic vic_vld;
    idx_t vic_idx;
    cnt_t vic_cnt;
    cnt_t vic_birth;
    key_t vic_key;
    logic free_vld;
    idx_t free_idx;
  } tok_t;

  // broadcast update to one cell
  typedef struct packed {
    logic en;
    logic fill;   // 1: new entry, 0: bump use count
    idx_t idx;
    key_t key;
    cnt_t birth;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

### src/lfu_if.sv
// Handshake interfaces for the request, response and configuration channels.
// Depends on lfu_pkg.
interface lfu_req_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  key_t ref_key;
  modport source (output valid, output ref_key, input ready);
  modport sink (input valid, input ref_key, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  logic hit;
  logic evicted_valid;
  key_t evicted_key;
  occ_t occupancy;
  modport source (output valid, output hit, output evicted_valid, output evicted_key,
                  output occupancy, input ready);
  modport sink (input valid, input hit, input evicted_valid, input evicted_key,
                input occupancy, output ready);
endinterface

interface lfu_cfg_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/lfu_frame_replacement.sv
// LFU frame replacement: each request word walks a row of FRAMES cells, one cell
// per cycle, collecting hit, victim and free frame; a write state then updates a cell.
// A request is taken only in the idle state, so the next one waits until the previous
// one has passed the write state; a new request is taken while the previous response
// still waits, and the write state holds while the response register is full and unread.
// Reset (rst, synchronous): all frames empty, sequence and occupancy zero, limit 32.
module lfu_frame_replacement (
  input logic    clk,
  input logic    rst,
  lfu_cfg_if.sink cfg,
  lfu_req_if.sink req,
  lfu_rsp_if.source rsp
);
  import lfu_pkg::*;

  state_t state;
  state_t state_next;
  tok_t   tok [FRAMES+1];
  tok_t   launch;
  tok_t   fin;
  wr_t    wr;
  cfg_t   active_frames;
  cnt_t   seq;
  occ_t   held_count;
  occ_t   limit;
  logic   can_out;
  logic   apply;
  logic   evict;
  logic   take_free;
  logic   rsp_valid;
  logic   rsp_hit;
  logic   rsp_ev;
  key_t   rsp_ev_key;
  occ_t   rsp_occ;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_frames <= cfg_t'(32);
    end else if (cfg.valid) begin
      active_frames <= cfg.data;
    end
  end

  always_comb begin
    if (active_frames == '0) begin
      limit = occ_t'(1);
    end else if (OCC_W'(active_frames) > occ_t'(FRAMES)) begin
      limit = occ_t'(FRAMES);
    end else begin
      limit = OCC_W'(active_frames);
    end
  end

  // launch word
  always_comb begin
    launch     = '0;
    launch.vld = req.valid && req.ready;
    launch.key = req.ref_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0] <= '0;
    end else begin
      tok[0] <= launch;
    end
  end

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (idx_t'(i)),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .wr       (wr)
    );
  end

  always_ff @(posedge clk) begin
    if (tok[FRAMES].vld) begin
      fin <= tok[FRAMES];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign can_out = !rsp_valid || rsp.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req.valid) state_next = ST_SCAN;
      ST_SCAN:  if (tok[FRAMES].vld) state_next = ST_WRITE;
      ST_WRITE: if (can_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    apply     = 1'b0;
    unique case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_SCAN:  ;
      ST_WRITE: apply = can_out;
      default:  ;
    endcase
  end

  assign evict     = !fin.found && (held_count >= limit) && fin.vic_vld;
  assign take_free = !fin.found && !evict && fin.free_vld;

  always_comb begin
    wr.en    = apply && (fin.found || evict || take_free);
    wr.fill  = !fin.found;
    wr.key   = fin.key;
    wr.birth = seq;
    if (fin.found) begin
      wr.idx = fin.hit_idx;
    end else if (evict) begin
      wr.idx = fin.vic_idx;
    end else begin
      wr.idx = fin.free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= '0;
      held_count <= '0;
    end else if (apply) begin
      if (seq != '1) begin
        seq <= seq + cnt_t'(1);
      end
      if (take_free) begin
        held_count <= held_count + occ_t'(1);
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      rsp_hit    <= fin.found;
      rsp_ev     <= evict;
      rsp_ev_key <= evict ? fin.vic_key : '0;
      rsp_occ    <= take_free ? held_count + occ_t'(1) : held_count;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.hit           = rsp_hit;
  assign rsp.evicted_valid = rsp_ev;
  assign rsp.evicted_key   = rsp_ev_key;
  assign rsp.occupancy     = rsp_occ;

endmodule

### src/lfu_cell.sv
// One frame of the replacement table plus its stage of the search row.
// Depends on lfu_pkg.
module lfu_cell (
  input  logic          clk,
  input  logic          rst,
  input  lfu_pkg::idx_t cell_idx,
  input  lfu_pkg::tok_t tok_in,
  output lfu_pkg::tok_t tok_out,
  input  lfu_pkg::wr_t  wr
);
  import lfu_pkg::*;

  logic valid;
  key_t key;
  cnt_t count;
  cnt_t birth;
  logic match;
  logic worse;
  tok_t tok_next;

  assign match = valid && (key == tok_in.key);

  // lower count, then older birth, then lower key
  assign worse = valid && (!tok_in.vic_vld || (count < tok_in.vic_cnt) ||
                 ((count == tok_in.vic_cnt) && ((birth < tok_in.vic_birth) ||
                 ((birth == tok_in.vic_birth) && (key < tok_in.vic_key)))));

  always_comb begin
    tok_next = tok_in;
    if (match && !tok_in.found) begin
      tok_next.found   = 1'b1;
      tok_next.hit_idx = cell_idx;
    end
    if (worse) begin
      tok_next.vic_vld   = 1'b1;
      tok_next.vic_idx   = cell_idx;
      tok_next.vic_cnt   = count;
      tok_next.vic_birth = birth;
      tok_next.vic_key   = key;
    end
    if (!valid && !tok_in.free_vld) begin
      tok_next.free_vld = 1'b1;
      tok_next.free_idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && (wr.idx == cell_idx) && wr.fill) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      if (wr.fill) begin
        key   <= wr.key;
        count <= cnt_t'(1);
        birth <= wr.birth;
      end else if (count != '1) begin
        count <= count + cnt_t'(1);
      end
    end
  end

endmodule

### src/lfu_frame_replacement_chk.sv
// Port-level checks for lfu_frame_replacement, attached with a bind.
// Depends on lfu_pkg and the top level's interface ports.
module lfu_frame_replacement_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input logic          hit,
  input logic          evicted_valid,
  input lfu_pkg::key_t evicted_key,
  input lfu_pkg::occ_t occupancy
);
  import lfu_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(evicted_valid) &&
    $stable(evicted_key) && $stable(occupancy))
    else $error("response word changed while stalled");

  a_occ_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> occupancy <= occ_t'(FRAMES))
    else $error("occupancy above frame count");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && hit |-> !evicted_valid)
    else $error("hit with eviction");

  a_ev_key_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !evicted_valid |-> evicted_key == '0 && occupancy != '0 || hit == 1'b0
      && evicted_key == '0)
    else $error("evicted key nonzero without eviction");

  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("response right after request accept");

endmodule

bind lfu_frame_replacement lfu_frame_replacement_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .hit           (rsp.hit),
  .evicted_valid (rsp.evicted_valid),
  .evicted_key   (rsp.evicted_key),
  .occupancy     (rsp.occupancy)
);

### bench/tb_top.sv
// Self-checking bench for lfu_frame_replacement: directed table, then random traffic.
// Depends on lfu_pkg and the lfu_req_if / lfu_rsp_if / lfu_cfg_if interfaces.
// Results are checked in order against an in-bench LFU predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lfu_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DIR_ROWS     = 25;

  typedef struct packed {
    logic hit;
    logic ev;
    key_t ev_key;
    occ_t occ;
  } lfu_result_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  arg;
    logic        typed;
    lfu_result_t want;
  } stim_row_t;

  localparam lfu_result_t NO_CHECK = '0;

  // typed rows: results that follow directly from reset and the first eviction
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_REF, 8'h00, 1'b1, '{1'b0, 1'b0, 8'h00, 6'd1}},
    '{ROW_REF, 8'hFF, 1'b1, '{1'b0, 1'b0, 8'h00, 6'd2}},
    '{ROW_REF, 8'h00, 1'b1, '{1'b1, 1'b0, 8'h00, 6'd2}},
    '{ROW_REF, 8'h55, 1'b1, '{1'b0, 1'b0, 8'h00, 6'd3}},
    '{ROW_REF, 8'hAA, 1'b1, '{1'b0, 1'b0, 8'h00, 6'd4}},
    '{ROW_CFG, 8'h02, 1'b0, NO_CHECK},  // limit below occupancy
    '{ROW_REF, 8'h01, 1'b1, '{1'b0, 1'b1, 8'hFF, 6'd4}},
    '{ROW_REF, 8'h02, 1'b0, NO_CHECK},
    '{ROW_REF, 8'hFF, 1'b0, NO_CHECK},
    '{ROW_REF, 8'h00, 1'b0, NO_CHECK},
    '{ROW_CFG, 8'h00, 1'b0, NO_CHECK},  // zero acts as one
    '{ROW_REF, 8'h03, 1'b0, NO_CHECK},
    '{ROW_REF, 8'h03, 1'b0, NO_CHECK},
    '{ROW_REF, 8'h04, 1'b0, NO_CHECK},
    '{ROW_CFG, 8'h3F, 1'b0, NO_CHECK},  // above FRAMES acts as FRAMES
    '{ROW_REF, 8'h10, 1'b0, NO_CHECK},
    '{ROW_REF, 8'h11, 1'b0, NO_CHECK},
    '{ROW_REF, 8'h12, 1'b0, NO_CHECK},
    '{ROW_REF, 8'h10, 1'b0, NO_CHECK},
    '{ROW_CFG, 8'h01, 1'b0, NO_CHECK},
    '{ROW_REF, 8'h80, 1'b0, NO_CHECK},
    '{ROW_REF, 8'h7F, 1'b0, NO_CHECK},
    '{ROW_REF, 8'h80, 1'b0, NO_CHECK},
    '{ROW_REF, 8'h10, 1'b0, NO_CHECK},
    '{ROW_CFG, 8'h20, 1'b0, NO_CHECK}
  };

  logic clk = 1'b0;
  logic rst;
  bit   steady = 1'b0;
  int   mismatches = 0;
  int   cycles = 0;

  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();
  lfu_cfg_if cfg_ch ();

  lfu_frame_replacement i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit          fr_valid [FRAMES];
  key_t        fr_key   [FRAMES];
  cnt_t        fr_uses  [FRAMES];
  cnt_t        fr_birth [FRAMES];
  cnt_t        seq_no;
  int unsigned held;
  cfg_t        limit_reg;

  lfu_result_t pending_results [$];

  function automatic lfu_result_t lfu_predict(key_t key);
    lfu_result_t r;
    int found, slot, lim;
    bit worse;
    r = '0;
    found = -1;
    slot = -1;
    for (int i = 0; i < FRAMES; i++) begin
      if (found < 0 && fr_valid[i] && fr_key[i] == key) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (fr_uses[found] != '1) fr_uses[found]++;
    end else begin
      lim = int'(limit_reg);
      if (lim < 1) lim = 1;
      if (lim > FRAMES) lim = FRAMES;
      if (held >= lim) begin
        // victim: fewest uses, then oldest birth, then lowest key
        for (int i = 0; i < FRAMES; i++) begin
          if (fr_valid[i]) begin
            if (slot < 0) worse = 1'b1;
            else if (fr_uses[i] != fr_uses[slot]) worse = fr_uses[i] < fr_uses[slot];
            else if (fr_birth[i] != fr_birth[slot]) worse = fr_birth[i] < fr_birth[slot];
            else worse = fr_key[i] < fr_key[slot];
            if (worse) slot = i;
          end
        end
      end
      if (slot >= 0) begin
        r.ev = 1'b1;
        r.ev_key = fr_key[slot];
      end else begin
        for (int i = 0; i < FRAMES; i++) begin
          if (slot < 0 && !fr_valid[i]) slot = i;
        end
        if (slot >= 0) held++;
      end
      if (slot >= 0) begin
        fr_valid[slot] = 1'b1;
        fr_key[slot]   = key;
        fr_uses[slot]  = 1;
        fr_birth[slot] = seq_no;
      end
    end
    if (seq_no != '1) seq_no++;
    r.occ = occ_t'(held);
    return r;
  endfunction

  task automatic send_ref(key_t key, bit typed, lfu_result_t want);
    lfu_result_t r;
    while (!steady && $urandom_range(99) < 35) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.ref_key <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    r = lfu_predict(key);
    pending_results.push_back(typed ? want : r);
  endtask

  // only called with the block idle
  task automatic write_limit(cfg_t value);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    limit_reg = value;
  endtask

  // response side: check each word, then pick next ready
  always @(posedge clk) begin
    lfu_result_t got, want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.hit, rsp_ch.evicted_valid, rsp_ch.evicted_key, rsp_ch.occupancy};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response word: hit=%0b ev=%0b ev_key=%02h occ=%0d",
                 $realtime, got.hit, got.ev, got.ev_key, got.occ);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit || got.ev !== want.ev || got.ev_key !== want.ev_key ||
            got.occ !== want.occ) begin
          $display("%0t: mismatch exp hit=%0b ev=%0b ev_key=%02h occ=%0d",
                   $realtime, want.hit, want.ev, want.ev_key, want.occ);
          $display("%0t:          got hit=%0b ev=%0b ev_key=%02h occ=%0d",
                   $realtime, got.hit, got.ev, got.ev_key, got.occ);
          mismatches++;
        end
      end
    end
    rsp_ch.ready <= steady || ($urandom_range(99) >= 35);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int sent, phase, lim, pool, n, pick;
    int unsigned base;
    cfg_t value;
    key_t key;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.ref_key = '0;
    rsp_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    for (int i = 0; i < FRAMES; i++) fr_valid[i] = 1'b0;
    seq_no    = '0;
    held      = 0;
    limit_reg = cfg_t'(32);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_limit(cfg_t'(dir_rows[i].arg));
      else send_ref(key_t'(dir_rows[i].arg), dir_rows[i].typed, dir_rows[i].want);
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: value = cfg_t'(1);
        1: value = cfg_t'(32);
        2: value = cfg_t'(0);
        3: value = cfg_t'(63);
        4: value = cfg_t'(4);
        default: value = cfg_t'($urandom_range(0, 63));
      endcase
      write_limit(value);
      lim = int'(value);
      if (lim < 1) lim = 1;
      if (lim > FRAMES) lim = FRAMES;
      // key pool a bit larger than the limit keeps both hits and evictions frequent
      pool = lim + $urandom_range(0, lim) + 1;
      base = $urandom_range(0, 255);
      n    = $urandom_range(60, 160);
      for (int j = 0; j < n && sent < RANDOM_ITEMS; j++) begin
        pick = $urandom_range(99);
        if (pick < 40) key = key_t'(base + $urandom_range(0, 3));
        else if (pick < 90) key = key_t'(base + $urandom_range(0, pool - 1));
        else key = key_t'($urandom_range(0, 255));
        steady = (sent >= 600 && sent < 900);
        send_ref(key, 1'b0, NO_CHECK);
        sent++;
      end
      phase++;
    end
    steady = 1'b0;
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (FRAMES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
